FILE: design/ita_pkg.sv
// ita_pkg: shared types, constants and the digit-to-ascii function
// for the integer to ascii formatter; depends on nothing
package ita_pkg;

	localparam int TEXT_MAX = 11;
	localparam int IDX_W    = 4;

	localparam logic [2:0] MODE_HEX_LOWER = 3'd0;
	localparam logic [2:0] MODE_HEX_UPPER = 3'd1;
	localparam logic [2:0] MODE_UDEC      = 3'd2;
	localparam logic [2:0] MODE_SDEC      = 3'd3;
	localparam logic [2:0] MODE_CHAR      = 3'd4;

	localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_MINUS = 8'h2D;
	localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
	localparam logic [7:0]  CHAR_UPPER_A = 8'h41;

	// text of one value, stored least significant character first
	typedef struct packed {
		logic [TEXT_MAX-1:0][7:0] chars;
		logic [IDX_W-1:0]         len;
	} text_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		begin
			if (d < 4'd10) begin
				digit_char = CHAR_ZERO + {4'd0, d};
			end else begin
				base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
				digit_char = base + {4'd0, d} - 8'd10;
			end
		end
	endfunction

endpackage

FILE: design/ita_front.sv
// ita_front: takes a value and mode, classifies it and converts it to
// text one digit per cycle; depends on ita_pkg
module ita_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [31:0]         value,
	input  logic [2:0]          mode,
	output logic                busy,
	output logic                push,
	output ita_pkg::text_t      push_text,
	input  logic                full
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SIGN, ST_PUSH} state_t;

	state_t                                    state_q;
	logic [31:0]                               mag_q;
	logic                                      hex_q;
	logic                                      upper_q;
	logic                                      neg_q;
	logic [ita_pkg::IDX_W-1:0]                 n_q;
	logic [ita_pkg::TEXT_MAX-1:0][7:0]         chars_q;

	logic [63:0] prod;
	logic [31:0] q10;
	logic [31:0] rem_full;
	logic [31:0] quot;
	logic [3:0]  rem;
	logic [7:0]  ch;
	logic        accept;
	logic        is_num;
	logic        is_neg;

	assign prod     = {32'd0, mag_q} * {32'd0, ita_pkg::RECIP10};
	assign q10      = {3'd0, prod[63:35]};
	assign rem_full = mag_q - (q10 << 3) - (q10 << 1);
	assign quot     = hex_q ? (mag_q >> 4) : q10;
	assign rem      = hex_q ? mag_q[3:0] : rem_full[3:0];
	assign ch       = ita_pkg::digit_char(rem, upper_q);

	assign accept = start && (state_q == ST_IDLE);
	assign is_num = mode inside {ita_pkg::MODE_HEX_LOWER, ita_pkg::MODE_HEX_UPPER,
		ita_pkg::MODE_UDEC, ita_pkg::MODE_SDEC};
	assign is_neg = (mode == ita_pkg::MODE_SDEC) && value[31];

	assign busy           = (state_q != ST_IDLE);
	assign push           = (state_q == ST_PUSH) && !full;
	assign push_text.chars = chars_q;
	assign push_text.len   = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_num) begin
							n_q     <= '0;
							state_q <= ST_CONV;
						end else begin
							n_q     <= ita_pkg::IDX_W'(1);
							state_q <= ST_PUSH;
						end
					end
				end
				ST_CONV: begin
					n_q <= n_q + 1'b1;
					if (quot == 32'd0) begin
						state_q <= neg_q ? ST_SIGN : ST_PUSH;
					end
				end
				ST_SIGN: begin
					n_q     <= n_q + 1'b1;
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mag_q   <= is_neg ? (~value + 32'd1) : value;
					hex_q   <= (mode == ita_pkg::MODE_HEX_LOWER) ||
						(mode == ita_pkg::MODE_HEX_UPPER);
					upper_q <= (mode == ita_pkg::MODE_HEX_UPPER);
					neg_q   <= is_neg;
					if (!is_num) begin
						chars_q[0] <= value[7:0];
					end
				end
			end
			ST_CONV: begin
				chars_q[n_q] <= ch;
				mag_q        <= quot;
			end
			ST_SIGN: begin
				chars_q[n_q] <= ita_pkg::CHAR_MINUS;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/ita_queue.sv
// ita_queue: short fifo of finished texts between front and back
// depends on ita_pkg
module ita_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ita_pkg::text_t  push_text,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output ita_pkg::text_t  head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ita_pkg::text_t     mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign valid = (count_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_text;
		end
	end

endmodule

FILE: design/ita_back.sv
// ita_back: emits the queued text one character per cycle, most
// significant first; depends on ita_pkg
module ita_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid,
	input  ita_pkg::text_t             head,
	output logic                       pop,
	output logic                       strobe,
	output logic [7:0]                 character,
	output logic                       last,
	output logic [ita_pkg::IDX_W-1:0]  length
);

	logic                       active_q;
	logic [ita_pkg::IDX_W-1:0]  idx_q;
	logic                       strobe_q;
	logic [7:0]                 character_q;
	logic                       last_q;
	logic [ita_pkg::IDX_W-1:0]  length_q;

	assign pop       = active_q && (idx_q == '0);
	assign strobe    = strobe_q;
	assign character = character_q;
	assign last      = last_q;
	assign length    = length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			strobe_q    <= 1'b0;
			character_q <= '0;
			last_q      <= 1'b0;
			length_q    <= '0;
		end else begin
			if (!active_q) begin
				strobe_q <= 1'b0;
				if (valid) begin
					active_q <= 1'b1;
					idx_q    <= head.len - 1'b1;
				end
			end else begin
				strobe_q    <= 1'b1;
				character_q <= head.chars[idx_q];
				last_q      <= (idx_q == '0);
				length_q    <= (idx_q == '0) ? head.len : '0;
				if (idx_q == '0) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

endmodule

FILE: design/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level, front converter, text queue and
// character emitter; depends on ita_pkg, ita_front, ita_queue, ita_back
//
// channel   direction  handshake           payload
// command   in         start, busy         value[31:0], mode[2:0]
// text      out        strobe (no stall)   character[7:0], last, length[3:0]
//
// front: takes a value in idle, writes each digit in conv (a divide-by-ten multiply
// or a nibble shift), adds a minus sign in sign, then hands off in push while not full
// character mode goes straight from idle to push in the front
// back: loads each text while inactive, then emits one character per cycle
// two texts queue between the two, so a new value is taken while text streams
// arst_n clears all control state; the receiver cannot stall the output
module integer_to_ascii_formatter #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic [2:0]  mode,
	output logic        strobe,
	output logic [7:0]  character,
	output logic        last,
	output logic [3:0]  length
);

	logic            push;
	logic            full;
	logic            pop;
	logic            valid;
	ita_pkg::text_t  push_text;
	ita_pkg::text_t  head;

	ita_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.mode      (mode),
		.busy      (busy),
		.push      (push),
		.push_text (push_text),
		.full      (full)
	);

	ita_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_text (push_text),
		.full      (full),
		.pop       (pop),
		.valid     (valid),
		.head      (head)
	);

	ita_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid),
		.head      (head),
		.pop       (pop),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.length    (length)
	);

	a_last_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> (length != 4'd0) && (length <= 4'd11))
		else $error("bad length on last character");

	a_mid_len: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> (length == 4'd0))
		else $error("length set before last character");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("transfer taken but front not busy");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("queue written while full");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("queue read while empty");

endmodule
